>>> rtl/core/stepper_position_follower_core_defines.svh
// Assertion macros for the stepper position follower checker.
// No dependencies; included by files that carry assertions.
`ifndef STEPPER_POSITION_FOLLOWER_CORE_DEFINES_SVH
`define STEPPER_POSITION_FOLLOWER_CORE_DEFINES_SVH

// same-cycle implication, disabled during reset
`define SPF_ASSERT_IMPLY(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
      else $error("spf check failed: implication");

// next-cycle implication, disabled during reset
`define SPF_ASSERT_NEXT(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
      else $error("spf check failed: next cycle");

`endif

>>> rtl/core/spf_pkg.sv
// Shared types and constants of the stepper position follower.
// No dependencies; imported by controller, datapath and top level.
`timescale 1ns / 1ps

package spf_pkg;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_PREP,
      ST_DIV,
      ST_DONE
   } ctrl_state_type;

   typedef struct packed {
      logic load;      // latch the accepted transaction
      logic prep;      // distance, direction, divider init
      logic div_step;  // one restoring divide step
      logic finish;    // commit axis state, load result register
   } dp_cmd_type;

   typedef struct packed {
      logic axis_ok;   // incoming axis is in range
      logic at_target; // latched axis already sits at target
      logic div_last;  // current divide step is the last one
      logic out_free;  // result register can take a new result
   } dp_status_type;

   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 32;

   localparam logic [CSR_INDEX_W-1:0] CSR_ACCEL_NUMERATOR = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_MIN_PERIOD      = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_INVERT_DIR_MASK = 2'd2;

   localparam int INVERT_BITS = 3;

   localparam logic [31:0] ACCEL_RESET      = 32'd1000000;
   localparam logic [15:0] MIN_PERIOD_RESET = 16'd99;
   localparam logic [15:0] IDLE_PERIOD      = 16'd999;
   localparam logic [15:0] PERIOD_MAX       = 16'hFFFF;

   localparam int DIV_STEPS = 32;
   localparam int DIV_CNT_W = 5;

endpackage

>>> rtl/core/spf_ctrl.sv
// Controller state machine of the stepper position follower.
// Depends on spf_pkg; drives datapath commands from datapath status.
`timescale 1ns / 1ps

module spf_ctrl import spf_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   input  dp_status_type status,
   output dp_cmd_type    cmd
);

   ctrl_state_type state_ff;
   ctrl_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            // out-of-range axis: transaction is taken and dropped
            if (req_valid && status.axis_ok) begin
               cmd.load = 1'b1;
               state_in = ST_PREP;
            end
         end
         ST_PREP: begin
            cmd.prep = 1'b1;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            if (status.at_target) begin
               state_in = ST_DONE;
            end else begin
               cmd.div_step = 1'b1;
               if (status.div_last) begin
                  state_in = ST_DONE;
               end
            end
         end
         ST_DONE: begin
            if (status.out_free) begin
               cmd.finish = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

>>> rtl/core/spf_datapath.sv
// Datapath of the stepper position follower: config registers, per-axis
// state, serial divider, pulse logic and result register. Depends on spf_pkg.
`timescale 1ns / 1ps

module spf_datapath import spf_pkg::*; #(
   parameter int AXIS_COUNT    = 3,
   parameter int POSITION_BITS = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic [1:0]             req_axis,
   input  logic signed [15:0]     req_target_position,
   input  logic                   csr_write_en,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   input  dp_cmd_type             cmd,
   output dp_status_type          status,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [15:0]            rsp_next_period,
   output logic                   rsp_dir_pin_write,
   output logic                   rsp_dir_pin_level,
   output logic                   rsp_step_pin_write,
   output logic                   rsp_step_pin_level,
   output logic signed [15:0]     rsp_position_now
);

   localparam int EXT_W = ((POSITION_BITS > 16) ? POSITION_BITS : 16) + 1;

   // configuration
   logic [31:0]            accel_ff;
   logic [15:0]            min_period_ff;
   logic [INVERT_BITS-1:0] invert_ff;

   // latched transaction
   logic [1:0]  axis_ff;
   logic [15:0] target_ff;

   // per-axis state
   logic [POSITION_BITS-1:0] pos_ff [AXIS_COUNT];
   logic [AXIS_COUNT-1:0]    phase_ff;
   logic [AXIS_COUNT-1:0]    lastdir_ff;

   // prep and divider
   logic [EXT_W-1:0]     dist_ff;
   logic                 lt_ff;
   logic                 at_target_ff;
   logic [EXT_W-1:0]     rem_ff;
   logic [31:0]          quo_ff;
   logic [DIV_CNT_W-1:0] cnt_ff;

   // result register
   logic        rsp_valid_ff;
   logic [15:0] period_ff;
   logic        dir_w_ff;
   logic        dir_l_ff;
   logic        step_w_ff;
   logic        step_l_ff;
   logic [15:0] pos_out_ff;

   // selected axis
   logic [POSITION_BITS-1:0] cur_pos;
   logic                     cur_phase;
   logic                     cur_lastdir;
   logic                     cur_inv;

   logic signed [EXT_W-1:0] now_ext;
   logic signed [EXT_W-1:0] tgt_ext;
   logic                    lt_now;
   logic [EXT_W-1:0]        dist_now;

   logic [EXT_W:0] trial;
   logic [EXT_W:0] trial_diff;
   logic           fits;

   logic [15:0]              floor_p;
   logic [15:0]              period_in;
   logic                     want;
   logic                     dir_w_in;
   logic                     dir_l_in;
   logic                     step_w_in;
   logic                     step_l_in;
   logic [POSITION_BITS-1:0] pos_in;
   logic                     phase_in;
   logic                     lastdir_in;
   logic [POSITION_BITS+15:0] pos_ze;

   always_ff @(posedge clock) begin
      if (reset) begin
         accel_ff      <= ACCEL_RESET;
         min_period_ff <= MIN_PERIOD_RESET;
         invert_ff     <= '0;
      end else if (csr_write_en) begin
         case (csr_index)
            CSR_ACCEL_NUMERATOR: accel_ff      <= csr_wdata;
            CSR_MIN_PERIOD:      min_period_ff <= csr_wdata[15:0];
            CSR_INVERT_DIR_MASK: invert_ff     <= csr_wdata[INVERT_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      cur_pos     = '0;
      cur_phase   = 1'b0;
      cur_lastdir = 1'b0;
      cur_inv     = 1'b0;
      for (int a = 0; a < AXIS_COUNT; a++) begin
         if (int'(axis_ff) == a) begin
            cur_pos     = pos_ff[a];
            cur_phase   = phase_ff[a];
            cur_lastdir = lastdir_ff[a];
         end
      end
      for (int i = 0; i < INVERT_BITS; i++) begin
         if (int'(axis_ff) == i) begin
            cur_inv = invert_ff[i];
         end
      end
   end

   assign now_ext  = {{(EXT_W-POSITION_BITS){cur_pos[POSITION_BITS-1]}}, cur_pos};
   assign tgt_ext  = {{(EXT_W-16){target_ff[15]}}, target_ff};
   assign lt_now   = now_ext < tgt_ext;
   assign dist_now = lt_now ? EXT_W'(tgt_ext - now_ext) : EXT_W'(now_ext - tgt_ext);

   assign trial      = {rem_ff, quo_ff[31]};
   assign fits       = trial >= {1'b0, dist_ff};
   assign trial_diff = trial - {1'b0, dist_ff};

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         axis_ff   <= req_axis;
         target_ff <= req_target_position;
      end
      if (cmd.prep) begin
         dist_ff      <= dist_now;
         lt_ff        <= lt_now;
         at_target_ff <= (now_ext == tgt_ext);
         rem_ff       <= '0;
         quo_ff       <= accel_ff;
         cnt_ff       <= '0;
      end else if (cmd.div_step) begin
         rem_ff <= fits ? trial_diff[EXT_W-1:0] : trial[EXT_W-1:0];
         quo_ff <= {quo_ff[30:0], fits};
         cnt_ff <= cnt_ff + 1'b1;
      end
   end

   // clamp, then pulse machine for the selected axis
   always_comb begin
      floor_p    = (min_period_ff == '0) ? 16'd1 : min_period_ff;
      want       = ~lt_ff;
      dir_w_in   = 1'b0;
      dir_l_in   = 1'b0;
      step_w_in  = 1'b0;
      step_l_in  = 1'b0;
      pos_in     = cur_pos;
      phase_in   = cur_phase;
      lastdir_in = cur_lastdir;
      if (quo_ff < {16'b0, floor_p}) begin
         period_in = floor_p;
      end else if (quo_ff > {16'b0, PERIOD_MAX}) begin
         period_in = PERIOD_MAX;
      end else begin
         period_in = quo_ff[15:0];
      end
      if (at_target_ff) begin
         period_in = IDLE_PERIOD;
      end else if (!cur_phase) begin
         dir_w_in = 1'b1;
         dir_l_in = want ^ cur_inv;
         if (want != cur_lastdir) begin
            lastdir_in = want;     // direction change costs this tick
         end else begin
            step_w_in = 1'b1;
            phase_in  = 1'b1;
         end
      end else begin
         // pending step completes in the old direction
         step_w_in = 1'b1;
         step_l_in = 1'b1;
         phase_in  = 1'b0;
         pos_in    = cur_lastdir ? cur_pos - 1'b1 : cur_pos + 1'b1;
      end
   end

   assign pos_ze = {16'b0, pos_in};

   always_ff @(posedge clock) begin
      for (int a = 0; a < AXIS_COUNT; a++) begin
         if (reset) begin
            pos_ff[a]     <= '0;
            phase_ff[a]   <= 1'b0;
            lastdir_ff[a] <= 1'b0;
         end else if (cmd.finish && (int'(axis_ff) == a)) begin
            pos_ff[a]     <= pos_in;
            phase_ff[a]   <= phase_in;
            lastdir_ff[a] <= lastdir_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.finish) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         period_ff  <= period_in;
         dir_w_ff   <= dir_w_in;
         dir_l_ff   <= dir_l_in;
         step_w_ff  <= step_w_in;
         step_l_ff  <= step_l_in;
         pos_out_ff <= pos_ze[15:0];
      end
   end

   assign status.axis_ok   = int'(req_axis) < AXIS_COUNT;
   assign status.at_target = at_target_ff;
   assign status.div_last  = (cnt_ff == DIV_CNT_W'(DIV_STEPS - 1));
   assign status.out_free  = !rsp_valid_ff || rsp_ready;

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_next_period    = period_ff;
   assign rsp_dir_pin_write  = dir_w_ff;
   assign rsp_dir_pin_level  = dir_l_ff;
   assign rsp_step_pin_write = step_w_ff;
   assign rsp_step_pin_level = step_l_ff;
   assign rsp_position_now   = pos_out_ff;

endmodule

>>> rtl/core/stepper_position_follower_core.sv
// Top level of the three-axis step/direction position follower.
// Depends on spf_pkg, spf_ctrl and spf_datapath.
`timescale 1ns / 1ps

// Usage:
// - req channel (valid/ready): one timer tick per transaction, carrying
//   req_axis and that axis's req_target_position. A tick for an axis at or
//   above AXIS_COUNT is taken and dropped without a response.
// - rsp channel (valid/ready): one response per in-range tick with the timer
//   reload value, direction/step pin actions and the axis position after it.
// - csr port: single-cycle writes, index 0 accel numerator, 1 minimum
//   period, 2 direction invert mask. Write only while the block is idle.
// - Sequence: after acceptance a moving axis goes through a prep step, the
//   one-bit-per-cycle restoring divider and a commit step; an axis already
//   at target skips the divide steps and goes on to the commit step.
// - Set by the serial divider, a new tick is accepted only after the
//   previous one has been committed to the output register.
// - The result sits in an output register; a new tick is accepted while it
//   waits. If the receiver stalls, the next result is held until the
//   register drains, and ready stays low meanwhile.
// - Reset clears positions, pulse phases, directions and the config
//   registers to their defaults; no response is pending after reset.

module stepper_position_follower_core import spf_pkg::*; #(
   parameter int AXIS_COUNT    = 3,
   parameter int POSITION_BITS = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [1:0]             req_axis,
   input  logic signed [15:0]     req_target_position,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [15:0]            rsp_next_period,
   output logic                   rsp_dir_pin_write,
   output logic                   rsp_dir_pin_level,
   output logic                   rsp_step_pin_write,
   output logic                   rsp_step_pin_level,
   output logic signed [15:0]     rsp_position_now,
   input  logic                   csr_write_en,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   dp_cmd_type    cmd;
   dp_status_type status;

   spf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   spf_datapath #(
      .AXIS_COUNT    (AXIS_COUNT),
      .POSITION_BITS (POSITION_BITS)
   ) u_datapath (
      .clock               (clock),
      .reset               (reset),
      .req_axis            (req_axis),
      .req_target_position (req_target_position),
      .csr_write_en        (csr_write_en),
      .csr_index           (csr_index),
      .csr_wdata           (csr_wdata),
      .cmd                 (cmd),
      .status              (status),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_next_period     (rsp_next_period),
      .rsp_dir_pin_write   (rsp_dir_pin_write),
      .rsp_dir_pin_level   (rsp_dir_pin_level),
      .rsp_step_pin_write  (rsp_step_pin_write),
      .rsp_step_pin_level  (rsp_step_pin_level),
      .rsp_position_now    (rsp_position_now)
   );

endmodule

>>> rtl/core/spf_checker.sv
// Port-level checks of the stepper position follower, bound to the top level.
// Depends on stepper_position_follower_core_defines.svh.
`timescale 1ns / 1ps
`include "stepper_position_follower_core_defines.svh"

module spf_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [15:0] rsp_next_period,
   input logic        rsp_dir_pin_write,
   input logic        rsp_dir_pin_level,
   input logic        rsp_step_pin_write,
   input logic        rsp_step_pin_level
);

   // stalled response keeps its period
   `SPF_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_next_period))

   // timer period is never zero
   `SPF_ASSERT_IMPLY(a_period_nonzero, clock, reset, rsp_valid, rsp_next_period != 16'd0)

   // an undriven pin reports level low
   `SPF_ASSERT_IMPLY(a_undriven_low, clock, reset, rsp_valid, (rsp_step_pin_write || !rsp_step_pin_level) && (rsp_dir_pin_write || !rsp_dir_pin_level))

   // the step rising edge tick never also drives direction
   `SPF_ASSERT_IMPLY(a_step_high_no_dir, clock, reset, rsp_valid && rsp_step_pin_level, !rsp_dir_pin_write)

endmodule

bind stepper_position_follower_core spf_checker u_spf_checker (
   .clock              (clock),
   .reset              (reset),
   .rsp_valid          (rsp_valid),
   .rsp_ready          (rsp_ready),
   .rsp_next_period    (rsp_next_period),
   .rsp_dir_pin_write  (rsp_dir_pin_write),
   .rsp_dir_pin_level  (rsp_dir_pin_level),
   .rsp_step_pin_write (rsp_step_pin_write),
   .rsp_step_pin_level (rsp_step_pin_level)
);

>>> dv/follower_tick_checker.sv
// Checker for the stepper position follower: watches req, rsp and csr traffic,
// predicts each response and compares it field by field.
// Depends on spf_pkg for the register indexes, reset values and idle period.
`timescale 1ns / 1ps

module follower_tick_checker import spf_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic                   req_ready,
   input  logic [1:0]             req_axis,
   input  logic signed [15:0]     req_target_position,
   input  logic                   rsp_valid,
   input  logic                   rsp_ready,
   input  logic [15:0]            rsp_next_period,
   input  logic                   rsp_dir_pin_write,
   input  logic                   rsp_dir_pin_level,
   input  logic                   rsp_step_pin_write,
   input  logic                   rsp_step_pin_level,
   input  logic signed [15:0]     rsp_position_now,
   input  logic                   csr_write_en,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   output int                     mismatch_count,
   output int                     ticks_in_flight
);

   localparam int NUM_AXES = 3;

   typedef struct packed {
      logic [15:0]        next_period;
      logic               dir_write;
      logic               dir_level;
      logic               step_write;
      logic               step_level;
      logic signed [15:0] position_now;
   } tick_response_type;

   // model copy of the axis state and the config registers
   logic signed [15:0] axis_pos [NUM_AXES];
   logic               step_high_pending [NUM_AXES];
   logic               heading_negative [NUM_AXES];
   logic [31:0]        accel_num;
   logic [15:0]        period_floor;
   logic [2:0]         dir_invert;

   tick_response_type expected_responses [$];
   tick_response_type predicted;
   tick_response_type oldest;
   bit                has_response;

   initial begin
      mismatch_count  = 0;
      ticks_in_flight = 0;
   end

   task automatic predict_tick(input logic [1:0] ax, input logic signed [15:0] target,
                               output bit produced, output tick_response_type r);
      int          a;
      int          now_pos;
      int          goal;
      logic [31:0] span;
      logic [31:0] quot;
      logic [31:0] floor_v;
      logic        want_negative;
      produced = 1'b0;
      r        = '0;
      if (ax < NUM_AXES) begin
         produced = 1'b1;
         a        = ax;
         now_pos  = axis_pos[a];
         goal     = target;
         if (now_pos == goal) begin
            r.next_period = IDLE_PERIOD;
         end else begin
            span    = (now_pos < goal) ? 32'(goal - now_pos) : 32'(now_pos - goal);
            quot    = accel_num / span;
            floor_v = (period_floor == 16'd0) ? 32'd1 : {16'd0, period_floor};
            if (quot < floor_v) quot = floor_v;
            if (quot > {16'd0, PERIOD_MAX}) quot = {16'd0, PERIOD_MAX};
            r.next_period = quot[15:0];
            if (!step_high_pending[a]) begin
               want_negative = !(now_pos < goal);
               r.dir_write   = 1'b1;
               r.dir_level   = want_negative ^ dir_invert[a];
               if (want_negative != heading_negative[a]) begin
                  // direction change burns this tick, no step
                  heading_negative[a] = want_negative;
               end else begin
                  r.step_write         = 1'b1;
                  r.step_level         = 1'b0;
                  step_high_pending[a] = 1'b1;
               end
            end else begin
               // pending rising edge finishes in the latched direction
               r.step_write         = 1'b1;
               r.step_level         = 1'b1;
               step_high_pending[a] = 1'b0;
               axis_pos[a] = heading_negative[a] ? axis_pos[a] - 16'sd1
                                                 : axis_pos[a] + 16'sd1;
            end
         end
         r.position_now = axis_pos[a];
      end
   endtask

   task automatic compare_field(input string field, input int exp_v, input int act_v);
      if (exp_v != act_v) begin
         $error("%s mismatch: expected %0d, actual %0d", field, exp_v, act_v);
         mismatch_count++;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         for (int a = 0; a < NUM_AXES; a++) begin
            axis_pos[a]          = '0;
            step_high_pending[a] = 1'b0;
            heading_negative[a]  = 1'b0;
         end
         accel_num    = ACCEL_RESET;
         period_floor = MIN_PERIOD_RESET;
         dir_invert   = '0;
         expected_responses.delete();
         ticks_in_flight <= 0;
      end else begin
         if (csr_write_en) begin
            case (csr_index)
               CSR_ACCEL_NUMERATOR: accel_num    = csr_wdata;
               CSR_MIN_PERIOD:      period_floor = csr_wdata[15:0];
               CSR_INVERT_DIR_MASK: dir_invert   = csr_wdata[INVERT_BITS-1:0];
               default: ;
            endcase
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_responses.size() == 0) begin
               $error("response transaction with nothing expected: period %0d position %0d",
                      rsp_next_period, rsp_position_now);
               mismatch_count++;
            end else begin
               oldest = expected_responses.pop_front();
               compare_field("next_period", oldest.next_period, rsp_next_period);
               compare_field("dir_pin_write", oldest.dir_write, rsp_dir_pin_write);
               compare_field("dir_pin_level", oldest.dir_level, rsp_dir_pin_level);
               compare_field("step_pin_write", oldest.step_write, rsp_step_pin_write);
               compare_field("step_pin_level", oldest.step_level, rsp_step_pin_level);
               compare_field("position_now", oldest.position_now, rsp_position_now);
            end
         end
         if (req_valid && req_ready) begin
            predict_tick(req_axis, req_target_position, has_response, predicted);
            if (has_response) expected_responses.push_back(predicted);
         end
         ticks_in_flight <= expected_responses.size();
      end
   end

endmodule

>>> dv/tb.sv
// Testbench top for stepper_position_follower_core: clock, reset, tick and
// config stimulus with random idling; checking lives in follower_tick_checker.
// Depends on spf_pkg, follower_tick_checker and the core RTL.
`timescale 1ns / 1ps

module tb;
   import spf_pkg::*;

   localparam int                   CYCLE_LIMIT     = 600000;
   localparam int                   SETTLE_CYCLES   = 40;
   localparam int                   TICKS_PER_PHASE = 130;
   localparam int                   NUM_PHASES      = 6;
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE_INDEX = 2'd3;
   localparam logic [1:0]           BAD_AXIS        = 2'd3;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_ready;
   logic [1:0]             req_axis = '0;
   logic signed [15:0]     req_target_position = '0;
   logic                   rsp_valid;
   logic                   rsp_ready = 1'b0;
   logic [15:0]            rsp_next_period;
   logic                   rsp_dir_pin_write;
   logic                   rsp_dir_pin_level;
   logic                   rsp_step_pin_write;
   logic                   rsp_step_pin_level;
   logic signed [15:0]     rsp_position_now;
   logic                   csr_write_en = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;

   int mismatch_count;
   int ticks_in_flight;
   int cycle_count = 0;
   int burst_left = 0;
   int ready_mode = 0;
   int mode_timer = 100;
   int stall_left = 0;
   int goal [3] = '{0, 0, 0};

   always #2 clock = ~clock;

   stepper_position_follower_core uut (
      .clock, .reset,
      .req_valid, .req_ready, .req_axis, .req_target_position,
      .rsp_valid, .rsp_ready, .rsp_next_period, .rsp_dir_pin_write, .rsp_dir_pin_level,
      .rsp_step_pin_write, .rsp_step_pin_level, .rsp_position_now,
      .csr_write_en, .csr_index, .csr_wdata
   );

   follower_tick_checker checker_i (
      .clock, .reset,
      .req_valid, .req_ready, .req_axis, .req_target_position,
      .rsp_valid, .rsp_ready, .rsp_next_period, .rsp_dir_pin_write, .rsp_dir_pin_level,
      .rsp_step_pin_write, .rsp_step_pin_level, .rsp_position_now,
      .csr_write_en, .csr_index, .csr_wdata,
      .mismatch_count, .ticks_in_flight
   );

   // receiver: switches between always-ready, coin-flip and long-stall modes
   always @(posedge clock) begin
      if (mode_timer == 0) begin
         ready_mode = $urandom_range(0, 2);
         mode_timer = $urandom_range(50, 400);
      end else begin
         mode_timer--;
      end
      if (stall_left != 0) begin
         stall_left--;
         rsp_ready <= 1'b0;
      end else begin
         case (ready_mode)
            0: rsp_ready <= 1'b1;
            1: rsp_ready <= 1'($urandom_range(0, 1));
            default: begin
               if ($urandom_range(0, 19) == 0) begin
                  stall_left = $urandom_range(5, 60);
                  rsp_ready <= 1'b0;
               end else begin
                  rsp_ready <= 1'b1;
               end
            end
         endcase
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   // one tick transaction; valid stays up across a burst
   task automatic send_tick(input logic [1:0] ax, input logic signed [15:0] target);
      int gap;
      if (burst_left == 0) begin
         gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
         burst_left = $urandom_range(1, 16);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      req_valid           <= 1'b1;
      req_axis            <= ax;
      req_target_position <= target;
      do @(posedge clock); while (!req_ready);
      burst_left--;
   endtask

   task automatic wait_for_responses();
      req_valid <= 1'b0;
      @(posedge clock);
      while (ticks_in_flight != 0) @(posedge clock);
      // settle margin; out-of-range ticks were already dropped on acceptance
      repeat (SETTLE_CYCLES) @(posedge clock);
      burst_left = 0;
   endtask

   task automatic configure(input logic [31:0] accel, input logic [15:0] min_p,
                            input logic [2:0] invert);
      csr_write_en <= 1'b1;
      csr_index    <= CSR_SPARE_INDEX;
      csr_wdata    <= $urandom;
      @(posedge clock);
      csr_index <= CSR_ACCEL_NUMERATOR;
      csr_wdata <= accel;
      @(posedge clock);
      csr_index <= CSR_MIN_PERIOD;
      csr_wdata <= {16'($urandom), min_p};
      @(posedge clock);
      csr_index <= CSR_INVERT_DIR_MASK;
      csr_wdata <= {29'($urandom), invert};
      @(posedge clock);
      csr_write_en <= 1'b0;
   endtask

   // mostly chase a held goal near zero so axes reach target and reverse
   task automatic random_tick(output bit counted);
      int          pick;
      logic [1:0]  ax;
      logic signed [15:0] target;
      pick    = $urandom_range(0, 99);
      counted = 1'b1;
      if (pick < 4) begin
         ax      = BAD_AXIS;
         target  = 16'($urandom);
         counted = 1'b0;
      end else begin
         ax = 2'($urandom_range(0, 2));
         if (pick < 70) begin
            target = 16'(goal[ax]);
         end else if (pick < 88) begin
            goal[ax] = int'($urandom_range(0, 40)) - 20;
            target   = 16'(goal[ax]);
         end else if (pick < 96) begin
            target = 16'($urandom);
         end else begin
            target = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
         end
      end
      send_tick(ax, target);
   endtask

   initial begin
      bit counted;
      int done;
      logic [31:0] accel;
      logic [15:0] min_p;
      logic [2:0]  invert;

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // directed, reset config
      send_tick(2'd0, 16'sd0);          // at target
      send_tick(2'd0, 16'sh7FFF);       // far positive: step low
      send_tick(2'd0, 16'sh8000);       // step high completes upward anyway
      send_tick(2'd0, 16'sh8000);       // direction change, no step
      send_tick(2'd0, 16'sh8000);
      send_tick(2'd0, 16'sd5);          // pending step high goes down
      repeat (7) send_tick(2'd1, 16'sd3);
      send_tick(BAD_AXIS, 16'sd1234);
      send_tick(BAD_AXIS, -16'sd1);
      repeat (5) send_tick(2'd2, -16'sd2);
      send_tick(2'd1, 16'sd3);

      for (int phase = 0; phase < NUM_PHASES; phase++) begin
         wait_for_responses();
         case (phase)
            0: begin accel = 32'hFFFF_FFFF; min_p = 16'd1; invert = 3'b111; end
            1: begin accel = 32'd0; min_p = 16'd0; invert = 3'b101; end
            2: begin accel = 32'd1; min_p = 16'hFFFF; invert = 3'b010; end
            3: begin
               accel  = $urandom_range(1000, 5000000);
               min_p  = 16'($urandom_range(1, 2000));
               invert = 3'($urandom);
            end
            default: begin
               accel  = $urandom;
               min_p  = 16'($urandom);
               invert = 3'($urandom);
            end
         endcase
         configure(accel, min_p, invert);
         done = 0;
         while (done < TICKS_PER_PHASE) begin
            random_tick(counted);
            if (counted) done++;
            if ($urandom_range(0, 99) == 0) wait_for_responses();
         end
      end

      wait_for_responses();
      if (mismatch_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

>>> sim.f
+incdir+rtl/core
rtl/core/spf_pkg.sv
rtl/core/spf_ctrl.sv
rtl/core/spf_datapath.sv
rtl/core/stepper_position_follower_core.sv
rtl/core/spf_checker.sv
dv/follower_tick_checker.sv
dv/tb.sv
